FILE: rtl/core/mseu_pkg.sv
`default_nettype none

package mseu_pkg;

	localparam int unsigned DATA_W          = 32;
	localparam int unsigned REG_CNT         = 32;
	localparam int unsigned REG_AW          = 5;
	localparam int unsigned TGT_W           = 10;
	localparam int unsigned STACK_WORDS_DEF = 1024;

	// operation codes; 10..15 are no-ops
	localparam logic [3:0] KIND_ADD  = 4'd0;
	localparam logic [3:0] KIND_SUB  = 4'd1;
	localparam logic [3:0] KIND_MUL  = 4'd2;
	localparam logic [3:0] KIND_DIV  = 4'd3;
	localparam logic [3:0] KIND_ADDI = 4'd4;
	localparam logic [3:0] KIND_SUBI = 4'd5;
	localparam logic [3:0] KIND_LW   = 4'd6;
	localparam logic [3:0] KIND_SW   = 4'd7;
	localparam logic [3:0] KIND_BEQ  = 4'd8;
	localparam logic [3:0] KIND_J    = 4'd9;

	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_DIV_ZERO = 2'd1;
	localparam logic [1:0] ERR_SLOT     = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_DIV,
		ST_WB
	} state_t;

	typedef struct packed {
		logic [3:0]               kind;
		logic [REG_AW-1:0]        dest_reg;
		logic [REG_AW-1:0]        src_a_reg;
		logic [REG_AW-1:0]        src_b_reg;
		logic signed [DATA_W-1:0] immediate;
		logic [TGT_W-1:0]         target_index;
	} cmd_t;

	typedef struct packed {
		logic                     taken;
		logic [TGT_W-1:0]         next_target;
		logic                     wrote_reg;
		logic signed [DATA_W-1:0] write_value;
		logic [1:0]               error_code;
	} res_t;

endpackage

`default_nettype wire

FILE: rtl/core/mseu_div.sv
`default_nettype none

// Signed divide, truncating toward zero. Restoring radix-2 on magnitudes,
// one quotient bit per cycle; done is a one-cycle pulse set with the last bit.
module mseu_div
	import mseu_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              go,
	input  wire logic [DATA_W-1:0] dividend,
	input  wire logic [DATA_W-1:0] divisor,
	output logic                   done,
	output logic [DATA_W-1:0]      quotient
);

	localparam int unsigned CNT_W = $clog2(DATA_W);

	logic              run_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] den_q;
	logic              neg_q;
	logic [DATA_W:0]   trial;
	logic [DATA_W:0]   shifted;

	assign shifted = {rem_q, quo_q[DATA_W-1]};
	assign trial   = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DATA_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			quo_q <= dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
			den_q <= divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
			neg_q <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
		end else if (run_q) begin
			if (!trial[DATA_W]) begin
				rem_q <= trial[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? (~quo_q + 1'b1) : quo_q;

endmodule

`default_nettype wire

FILE: rtl/core/mips_subset_execute_unit.sv
// Sequence: a command taken in IDLE goes to EXEC, then WB, where done
//   strobes the result; a div with a non-zero divisor waits in DIV for
//   the divider (one quotient bit per cycle). New commands wait for IDLE.
// Reset: the stack is swept to zero, one word a cycle, in ST_CLEAR with
//   busy high; the register file clears at once via valid bits.
// The receiver cannot stall: done marks the result for one cycle only.
`default_nettype none

module mips_subset_execute_unit
	import mseu_pkg::*;
#(
	parameter int unsigned STACK_WORDS = STACK_WORDS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  wire cmd_t cmd,
	output logic      done,
	output res_t      result
);

	localparam int unsigned SAW = $clog2(STACK_WORDS);
	localparam logic [SAW-1:0] CLR_LAST = SAW'(STACK_WORDS - 1);
	localparam logic [DATA_W+1:0] SLOT_MAX = (DATA_W+2)'(STACK_WORDS - 1);

	state_t state_q, state_nxt;

	// FSM outputs
	logic accept;
	logic in_exec;
	logic in_wb;
	logic clr_we;

	// register file: 32 words, two registered read ports, valid bits on reset
	logic [DATA_W-1:0]  rf_mem [REG_CNT];
	logic [REG_CNT-1:0] rf_vld_q;
	logic [DATA_W-1:0]  ra_q, rb_q;
	logic               ra_ok_q, rb_ok_q;
	logic [REG_AW-1:0]  rb_addr;

	// stack memory
	logic [DATA_W-1:0]  stk_mem [STACK_WORDS];
	logic [DATA_W-1:0]  stk_rd_q;
	logic [SAW-1:0]     clr_cnt_q;
	logic               stk_we;
	logic [SAW-1:0]     stk_waddr;
	logic [DATA_W-1:0]  stk_wdata;

	// issued transaction and slot decode
	cmd_t              cmd_s1;
	logic [DATA_W+1:0] imm_x, imm_adj, imm_q4;
	logic              slot_ok, slot_ok_s1;
	logic [SAW-1:0]    slot, slot_s1;

	// execute
	logic [DATA_W-1:0] op_a, op_b, mul_lo;
	logic [DATA_W-1:0] ex_val;
	logic              ex_taken, ex_wr, ex_sw, ex_lw, ex_div;
	logic [1:0]        ex_err;

	// result registers
	logic [DATA_W-1:0] val_q;
	logic              taken_q, wr_q, sw_q, lw_q;
	logic [1:0]        err_q;
	logic [DATA_W-1:0] wb_val;
	logic              wb_wrote;

	// divider
	logic              div_done;
	logic [DATA_W-1:0] div_quo;

	// ---------------- control ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (clr_we)
				clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_CLEAR: if (clr_cnt_q == CLR_LAST) state_nxt = ST_IDLE;
			ST_IDLE:  if (start) state_nxt = ST_EXEC;
			ST_EXEC:  state_nxt = ex_div ? ST_DIV : ST_WB;
			ST_DIV:   if (div_done) state_nxt = ST_WB;
			ST_WB:    state_nxt = ST_IDLE;
			default:  state_nxt = ST_CLEAR;
		endcase
	end

	always_comb begin
		busy    = 1'b1;
		accept  = 1'b0;
		in_exec = 1'b0;
		in_wb   = 1'b0;
		clr_we  = 1'b0;
		case (state_q)
			ST_CLEAR: clr_we = 1'b1;
			ST_IDLE: begin
				busy   = 1'b0;
				accept = start;
			end
			ST_EXEC:  in_exec = 1'b1;
			ST_DIV:   ;
			ST_WB:    in_wb = 1'b1;
			default:  ;
		endcase
	end

	// ---------------- issue: register reads and slot decode ----------------
	// sw needs the data register instead of the second source
	assign rb_addr = (cmd.kind == KIND_SW) ? cmd.dest_reg : cmd.src_b_reg;

	// offset/4 toward zero, slot = STACK_WORDS-1 - offset/4
	assign imm_x   = {{2{cmd.immediate[DATA_W-1]}}, cmd.immediate};
	assign imm_adj = imm_x + (cmd.immediate[DATA_W-1] ? (DATA_W+2)'(3) : '0);
	assign imm_q4  = {{2{imm_adj[DATA_W+1]}}, imm_adj[DATA_W+1:2]};
	assign slot_ok = !imm_q4[DATA_W+1] && (imm_q4 <= SLOT_MAX);
	assign slot    = SAW'(SLOT_MAX - imm_q4);

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1     <= cmd;
			slot_s1    <= slot;
			slot_ok_s1 <= slot_ok;
			ra_q       <= rf_mem[cmd.src_a_reg];
			rb_q       <= rf_mem[rb_addr];
			ra_ok_q    <= rf_vld_q[cmd.src_a_reg];
			rb_ok_q    <= rf_vld_q[rb_addr];
		end
		if (wb_wrote)
			rf_mem[cmd_s1.dest_reg] <= wb_val;
	end

	// register 0 is never written, so it always reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rf_vld_q <= '0;
		else if (wb_wrote)
			rf_vld_q[cmd_s1.dest_reg] <= 1'b1;
	end

	// ---------------- execute ----------------
	assign op_a   = ra_ok_q ? ra_q : '0;
	assign op_b   = rb_ok_q ? rb_q : '0;
	assign mul_lo = op_a * op_b;

	always_comb begin
		ex_val   = '0;
		ex_taken = 1'b0;
		ex_wr    = 1'b0;
		ex_sw    = 1'b0;
		ex_lw    = 1'b0;
		ex_div   = 1'b0;
		ex_err   = ERR_NONE;
		if (in_exec) begin
			case (cmd_s1.kind)
				KIND_ADD: begin
					ex_val = op_a + op_b;
					ex_wr  = 1'b1;
				end
				KIND_SUB: begin
					ex_val = op_a - op_b;
					ex_wr  = 1'b1;
				end
				KIND_MUL: begin
					ex_val = mul_lo;
					ex_wr  = 1'b1;
				end
				KIND_DIV: begin
					if (op_b == '0) begin
						ex_err = ERR_DIV_ZERO;
					end else begin
						ex_div = 1'b1;
						ex_wr  = 1'b1;
					end
				end
				KIND_ADDI: begin
					ex_val = op_a + cmd_s1.immediate;
					ex_wr  = 1'b1;
				end
				KIND_SUBI: begin
					ex_val = op_a - cmd_s1.immediate;
					ex_wr  = 1'b1;
				end
				KIND_LW: begin
					if (!slot_ok_s1) begin
						ex_err = ERR_SLOT;
					end else begin
						ex_lw = 1'b1;
						ex_wr = 1'b1;
					end
				end
				KIND_SW: begin
					if (!slot_ok_s1) begin
						ex_err = ERR_SLOT;
					end else begin
						ex_val = op_b;
						ex_sw  = 1'b1;
					end
				end
				KIND_BEQ: ex_taken = (op_a == op_b);
				KIND_J:   ex_taken = 1'b1;
				default:  ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_exec) begin
			val_q   <= ex_val;
			taken_q <= ex_taken;
			wr_q    <= ex_wr;
			sw_q    <= ex_sw;
			lw_q    <= ex_lw;
			err_q   <= ex_err;
		end else if (div_done) begin
			val_q <= div_quo;
		end
	end

	mseu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (ex_div),
		.dividend (op_a),
		.divisor  (op_b),
		.done     (div_done),
		.quotient (div_quo)
	);

	// ---------------- stack memory ----------------
	// one write port and one read port: the clear sweep and stores write, lw reads during execute
	assign stk_we    = clr_we || (in_wb && sw_q);
	assign stk_waddr = clr_we ? clr_cnt_q : slot_s1;
	assign stk_wdata = clr_we ? '0 : val_q;

	always_ff @(posedge clk) begin
		if (stk_we)
			stk_mem[stk_waddr] <= stk_wdata;
		if (ex_lw)
			stk_rd_q <= stk_mem[slot_s1];
	end

	// ---------------- writeback and result ----------------
	assign wb_val   = lw_q ? stk_rd_q : val_q;
	assign wb_wrote = in_wb && wr_q && (cmd_s1.dest_reg != '0);

	assign done               = in_wb;
	assign result.taken       = taken_q;
	assign result.next_target = taken_q ? cmd_s1.target_index : '0;
	assign result.wrote_reg   = wr_q && (cmd_s1.dest_reg != '0);
	assign result.write_value = wb_val;
	assign result.error_code  = err_q;

endmodule

`default_nettype wire
